### rtl/core/dpfp_pkg.sv
// dpfp_pkg: shared types, register codes and reset values for the DPLL
// phase detector / PI loop filter. No dependencies.
package dpfp_pkg;

    localparam int DEF_TIME_BITS = 48;
    localparam int CFG_W         = 32;
    localparam int CFG_ADDR_W    = 3;
    localparam int ERR_W         = 32;
    localparam int ACC_W         = 48;
    localparam int OUT_TDATA_W   = 128;
    localparam int OUT_TUSER_W   = 2;

    // queue between detector and filter pipeline
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // tuser bit positions of the result channel
    localparam int TU_DIR     = 0;
    localparam int TU_CLAMPED = 1;

    localparam logic [CFG_W-1:0] RST_NOMINAL = 32'd1000000;
    localparam logic [CFG_W-1:0] RST_MIN     = 32'd900000;
    localparam logic [CFG_W-1:0] RST_MAX     = 32'd1100000;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_NOMINAL    = 3'd0,
        REG_MIN        = 3'd1,
        REG_MAX        = 3'd2,
        REG_PROP_GAIN  = 3'd3,
        REG_INTEG_GAIN = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0]        nominal;
        logic [CFG_W-1:0]        min_lim;
        logic [CFG_W-1:0]        max_lim;
        logic signed [CFG_W-1:0] prop_gain;
        logic signed [CFG_W-1:0] integ_gain;
    } cfg_t;

    // one closed pair, handed from detector to filter
    typedef struct packed {
        logic                    dir;
        logic signed [ERR_W-1:0] err;
    } qent_t;

    typedef struct packed {
        logic                    dir;
        logic signed [ERR_W-1:0] err;
        logic signed [ERR_W-1:0] prop;
        logic signed [ERR_W-1:0] accus;
        logic [CFG_W-1:0]        interval;
        logic                    clamped;
    } res_t;

endpackage

### rtl/core/dpfp_front.sv
// dpfp_front: three-state edge detector and saturated phase difference.
// Depends on dpfp_pkg.
module dpfp_front import dpfp_pkg::*; #(
    parameter int TIME_BITS = DEF_TIME_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_mode,
    input  logic [TIME_BITS-1:0] in_stamp,
    input  logic                 q_full,
    output logic                 push,
    output qent_t                push_ent
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_UP   = 2'd1,
        ST_DOWN = 2'd2
    } det_state_t;

    det_state_t           state_reg, state_next;
    logic [TIME_BITS-1:0] ref_reg, ref_next;
    logic [TIME_BITS-1:0] osc_reg, osc_next;
    logic                 accept, close, dir;
    logic [TIME_BITS-1:0] diff;
    logic [TIME_BITS-32:0] diff_hi;
    logic                 fits;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb begin
        ref_next   = ref_reg;
        osc_next   = osc_reg;
        state_next = state_reg;
        close      = 1'b0;
        dir        = 1'b0;
        if (in_mode == 1'b0) begin
            ref_next = in_stamp;
            unique case (state_reg)
                ST_DOWN: begin
                    close      = 1'b1;
                    dir        = 1'b1;
                    state_next = ST_IDLE;
                end
                default: state_next = ST_UP;
            endcase
        end else begin
            osc_next = in_stamp;
            unique case (state_reg)
                ST_UP: begin
                    close      = 1'b1;
                    state_next = ST_IDLE;
                end
                default: state_next = ST_DOWN;
            endcase
        end
    end

    // wrapped difference, read as two's complement, saturated to 32 bits
    always_comb begin
        diff    = ref_next - osc_next;
        diff_hi = diff[TIME_BITS-1:31];
        fits    = (&diff_hi) || !(|diff_hi);
        push_ent.dir = dir;
        if (fits)
            push_ent.err = $signed(diff[31:0]);
        else if (diff[TIME_BITS-1])
            push_ent.err = 32'sh8000_0000;
        else
            push_ent.err = 32'sh7FFF_FFFF;
    end

    assign push = accept && close;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ref_reg   <= '0;
            osc_reg   <= '0;
        end else if (accept) begin
            state_reg <= state_next;
            ref_reg   <= ref_next;
            osc_reg   <= osc_next;
        end
    end

endmodule

### rtl/core/dpfp_queue.sv
// dpfp_queue: short register FIFO between detector and filter pipeline.
// Depends on dpfp_pkg.
module dpfp_queue import dpfp_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  qent_t push_ent,
    input  logic  pop,
    output logic  full,
    output logic  head_valid,
    output qent_t head
);

    qent_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              do_pop;

    assign full       = (cnt_reg == QCNT_W'(QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        if (p == QPTR_W'(QDEPTH - 1))
            return '0;
        else
            return p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_ent;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (!push && do_pop)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

### rtl/core/dpfp_back.sv
// dpfp_back: PI loop filter pipeline (multiply, integrate, round, clamp)
// with output register. Depends on dpfp_pkg.
module dpfp_back import dpfp_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  cfg_t  cfg,
    input  logic  q_valid,
    input  qent_t q_head,
    output logic  q_pop,
    output logic  out_valid,
    input  logic  out_ready,
    output res_t  out_res
);

    localparam int SUM_W  = CFG_W + 3;
    localparam int ASUM_W = 58;

    logic                     en;
    // stage 1: products
    logic                     s1_valid_reg;
    logic                     s1_dir_reg;
    logic signed [ERR_W-1:0]  s1_err_reg;
    logic signed [63:0]       s1_pprod_reg, s1_iprod_reg;
    // stage 2: integrate, proportional term
    logic                     s2_valid_reg;
    logic                     s2_dir_reg;
    logic signed [ERR_W-1:0]  s2_err_reg, s2_prop_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [63:0]       irnd, prnd;
    logic signed [ASUM_W-1:0] asum;
    logic signed [ERR_W-1:0]  prop_sat;
    // stage 3: accumulator rounded to whole us
    logic                     s3_valid_reg;
    logic                     s3_dir_reg;
    logic signed [ERR_W-1:0]  s3_err_reg, s3_prop_reg, s3_accus_reg;
    logic signed [ACC_W:0]    arnd;
    logic signed [ERR_W-1:0]  accus_sat;
    // output
    logic                     out_valid_reg;
    res_t                     out_reg;
    logic signed [SUM_W-1:0]  sum;
    logic [CFG_W-1:0]         interval;
    logic                     clamped;

    function automatic logic signed [ERR_W-1:0] sat32(input logic signed [63:0] v);
        logic [32:0] hi;
        hi = v[63:31];
        if ((&hi) || !(|hi))
            return v[31:0];
        else if (v[63])
            return 32'sh8000_0000;
        else
            return 32'sh7FFF_FFFF;
    endfunction

    assign en    = !out_valid_reg || out_ready;
    assign q_pop = en;

    // stage 2 arithmetic
    always_comb begin
        logic [ASUM_W-ACC_W:0] ahi;
        irnd = (s1_iprod_reg + 64'sd128) >>> 8;
        asum = $signed({{(ASUM_W-ACC_W){acc_reg[ACC_W-1]}}, acc_reg})
             + $signed(irnd[ASUM_W-1:0]);
        ahi  = asum[ASUM_W-1:ACC_W-1];
        if ((&ahi) || !(|ahi))
            acc_next = asum[ACC_W-1:0];
        else if (asum[ASUM_W-1])
            acc_next = {1'b1, {(ACC_W-1){1'b0}}};
        else
            acc_next = {1'b0, {(ACC_W-1){1'b1}}};
        prnd     = (s1_pprod_reg + (64'sd1 <<< 23)) >>> 24;
        prop_sat = sat32(prnd);
    end

    // stage 3 arithmetic
    always_comb begin
        arnd      = ($signed({acc_reg[ACC_W-1], acc_reg}) + (49'sd1 <<< 15)) >>> 16;
        accus_sat = sat32(64'(arnd));
    end

    // final sum and clamp, maximum tested first
    always_comb begin
        sum = $signed({3'b000, cfg.nominal})
            + SUM_W'(s3_prop_reg) + SUM_W'(s3_accus_reg);
        clamped  = 1'b1;
        if (sum > $signed({3'b000, cfg.max_lim}))
            interval = cfg.max_lim;
        else if (sum < $signed({3'b000, cfg.min_lim}))
            interval = cfg.min_lim;
        else begin
            interval = sum[CFG_W-1:0];
            clamped  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
        end else if (en) begin
            s1_valid_reg  <= q_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
            if (s1_valid_reg)
                acc_reg <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_dir_reg   <= q_head.dir;
            s1_err_reg   <= q_head.err;
            s1_pprod_reg <= 64'(q_head.err) * 64'(cfg.prop_gain);
            s1_iprod_reg <= 64'(q_head.err) * 64'(cfg.integ_gain);

            s2_dir_reg   <= s1_dir_reg;
            s2_err_reg   <= s1_err_reg;
            s2_prop_reg  <= prop_sat;

            s3_dir_reg   <= s2_dir_reg;
            s3_err_reg   <= s2_err_reg;
            s3_prop_reg  <= s2_prop_reg;
            s3_accus_reg <= accus_sat;

            out_reg.dir      <= s3_dir_reg;
            out_reg.err      <= s3_err_reg;
            out_reg.prop     <= s3_prop_reg;
            out_reg.accus    <= s3_accus_reg;
            out_reg.interval <= interval;
            out_reg.clamped  <= clamped;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

endmodule

### rtl/core/dpll_phase_detector_pi_filter.sv
// dpll_phase_detector_pi_filter: top level, configuration registers and
// wiring of detector, queue and filter pipeline. Depends on dpfp_pkg,
// dpfp_front, dpfp_queue, dpfp_back.
//
// Timestamped edge items come in on the s_ side; s_tuser[0] says whether the
// edge is a reference edge (0) or an oscillator edge (1). A three-state
// detector pairs a reference edge with the next oscillator edge in either
// order; each closed pair yields one result item on the m_ side, other items
// yield none. The block takes one item per clock, back to back, while m_tready
// is held high. A closed pair passes the queue and then the filter pipeline:
// one stage for the two 32x32 gain multiplies, one for the saturating 48-bit
// integrator (the only loop, from the accumulator back to itself), one for
// rounding the integrator, and the output register where the interval is summed
// and clamped. A two-entry queue decouples the detector from the pipeline; when
// the output is stalled the whole pipeline holds and s_tready drops once the
// queue is full. The five configuration registers are written through
// cfg_we/cfg_addr/cfg_wdata and should only change while no result is
// pending.
module dpll_phase_detector_pi_filter import dpfp_pkg::*; #(
    parameter int TIME_BITS = DEF_TIME_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input items
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [((TIME_BITS+7)/8)*8-1:0]    s_tdata,   // timestamp_us
    input  logic                              s_tuser,   // mode
    // result items
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // phase_error_us, proportional_us, accumulated_us, interval_us
    output logic [OUT_TDATA_W-1:0]            m_tdata,
    output logic [OUT_TUSER_W-1:0]            m_tuser,   // direction, clamped
    // configuration writes
    input  logic                              cfg_we,
    input  logic [CFG_ADDR_W-1:0]             cfg_addr,
    input  logic [CFG_W-1:0]                  cfg_wdata
);

    cfg_t  cfg_reg;
    logic  q_full, q_push, q_pop, q_valid;
    qent_t q_in, q_head;
    res_t  res;

    // register file; unknown indexes are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.nominal    <= RST_NOMINAL;
            cfg_reg.min_lim    <= RST_MIN;
            cfg_reg.max_lim    <= RST_MAX;
            cfg_reg.prop_gain  <= '0;
            cfg_reg.integ_gain <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_NOMINAL:    cfg_reg.nominal    <= cfg_wdata;
                REG_MIN:        cfg_reg.min_lim    <= cfg_wdata;
                REG_MAX:        cfg_reg.max_lim    <= cfg_wdata;
                REG_PROP_GAIN:  cfg_reg.prop_gain  <= $signed(cfg_wdata);
                REG_INTEG_GAIN: cfg_reg.integ_gain <= $signed(cfg_wdata);
                default: ;
            endcase
        end
    end

    dpfp_front #(
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_mode  (s_tuser),
        .in_stamp (s_tdata[TIME_BITS-1:0]),
        .q_full   (q_full),
        .push     (q_push),
        .push_ent (q_in)
    );

    dpfp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_ent   (q_in),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_valid),
        .head       (q_head)
    );

    dpfp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {res.interval, res.accus, res.prop, res.err};
    assign m_tuser = {res.clamped, res.dir};

endmodule

### rtl/core/dpfp_checker.sv
// dpfp_port_checker: port-level assertions for dpll_phase_detector_pi_filter,
// bound to the top level. Depends on dpfp_pkg.
module dpfp_port_checker import dpfp_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic [OUT_TUSER_W-1:0] m_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // input backpressure only comes from a stalled result
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !$past(aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind dpll_phase_detector_pi_filter dpfp_port_checker u_dpfp_checker (.*);
